### rtl/stt_pkg.sv
// Shared types and constants for the script text tokenizer.
// Holds character codes, the scanner phase encoding and the result entry layout.
// No dependencies.
package stt_pkg;

    localparam int TEXT_W = 8;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 10;

    localparam logic [TEXT_W-1:0] CH_NUL   = 8'h00;
    localparam logic [TEXT_W-1:0] CH_LF    = 8'h0A;
    localparam logic [TEXT_W-1:0] CH_CR    = 8'h0D;
    localparam logic [TEXT_W-1:0] CH_SPACE = 8'h20;
    localparam logic [TEXT_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [TEXT_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [TEXT_W-1:0] CH_SLASH = 8'h2F;

    // Scanner phase
    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_SLASH  = 3'd1,
        PH_LINE   = 3'd2,
        PH_BLOCK  = 3'd3,
        PH_STAR   = 3'd4,
        PH_STRING = 3'd5,
        PH_PLAIN  = 3'd6,
        PH_EOL    = 3'd7
    } phase_t;

    // Result kind
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOD  = 2'd2
    } kind_t;

    // Most results one text byte can cause
    localparam int MAX_RES = 3;

    typedef struct packed {
        kind_t              kind;
        logic [TEXT_W-1:0]  char_value;
        logic [POS_W-1:0]   position;
        logic [LEN_W-1:0]   token_length;
        logic               final_res;
    } res_t;

endpackage

### rtl/script_text_tokenizer.sv
// Script text tokenizer, top level.
// Uses stt_pkg for character codes, phase encoding and the result entry type.
//
// Usage:
//   Input stream (s_axis_*): one text byte per transfer, with the end-of-line
//   request flag on tuser. A zero byte marks end of data; the scanner then
//   returns to skipping whitespace and the next byte starts a new text.
//   Output stream (m_axis_*): zero to three results per text byte. tuser holds
//   the kind (token byte, token end, end of data), tlast marks the last result
//   caused by one text byte. A byte that causes no result (whitespace,
//   comment body) produces no output transfer.
// Path: a byte accepted into the input register is scanned from there, and
//   its results are registered into the result bank, which presents them.
// Throughput: one text byte per cycle while each byte causes at most one result
//   and m_axis_tready stays high; a byte with k results holds the three-entry
//   result bank for k output transfers, which sets the rate for those bytes.
// Stalls: the input register keeps accepting while a finished result waits;
//   once it is full too, s_axis_tready drops until the bank drains.
// Reset: synchronous, active low; scanner goes to whitespace skipping with
//   all token counters cleared, and both register stages are emptied.
module script_text_tokenizer #(
    parameter int TOKEN_CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] until_eol

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] char_value, [17:8] position,
                                        // [27:18] token_length, [31:28] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // final_res
);

    // Counter must hold the capacity itself
    localparam int CNT_W = $clog2(TOKEN_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(TOKEN_CAPACITY);

    // Input register stage
    logic                        in_valid_reg;
    logic [stt_pkg::TEXT_W-1:0]  in_byte_reg;
    logic                        in_eol_reg;

    // Scanner state
    stt_pkg::phase_t   phase_reg,       phase_next;
    logic              eol_mode_reg,    eol_mode_next;
    logic [CNT_W-1:0]  stored_cnt_reg,  stored_cnt_next;
    logic [CNT_W-1:0]  kept_len_reg,    kept_len_next;
    logic              last_quote_reg,  last_quote_next;
    logic              lead_quote_reg,  lead_quote_next;

    // Result bank: the results of one text byte, drained in order
    stt_pkg::res_t     res_reg  [stt_pkg::MAX_RES];
    stt_pkg::res_t     res_next [stt_pkg::MAX_RES];
    logic [1:0]        res_cnt_next;
    logic [1:0]        res_left_reg;
    logic [1:0]        rd_ptr_reg;

    logic bank_free;
    logic move;

    // Bank can take a new byte's results when empty or its last entry leaves now
    assign bank_free = (res_left_reg == 2'd0) ||
                       (res_left_reg == 2'd1 && m_axis_tready);
    assign move          = in_valid_reg && bank_free;
    assign s_axis_tready = !in_valid_reg || move;

    assign m_axis_tvalid = (res_left_reg != 2'd0);
    assign m_axis_tuser  = res_reg[rd_ptr_reg].kind;
    assign m_axis_tlast  = res_reg[rd_ptr_reg].final_res;
    assign m_axis_tdata  = {4'b0000,
                            res_reg[rd_ptr_reg].token_length,
                            res_reg[rd_ptr_reg].position,
                            res_reg[rd_ptr_reg].char_value};

    // Scan one text byte: next state plus up to three results
    always_comb begin : scan_logic
        stt_pkg::phase_t             ph;
        logic                        eol;
        logic [CNT_W-1:0]            sc;
        logic [CNT_W-1:0]            kl;
        logic                        lkq;
        logic                        lq;
        logic [1:0]                  n;
        logic                        do_begin;
        logic                        do_body;
        logic [stt_pkg::TEXT_W-1:0]  b;
        logic [stt_pkg::TEXT_W-1:0]  bb;
        logic [CNT_W-1:0]            len;

        ph  = phase_reg;
        eol = eol_mode_reg;
        sc  = stored_cnt_reg;
        kl  = kept_len_reg;
        lkq = last_quote_reg;
        lq  = lead_quote_reg;
        n   = 2'd0;
        b   = in_byte_reg;
        bb  = in_byte_reg;
        do_begin = 1'b0;
        do_body  = 1'b0;
        len = '0;

        for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
            res_next[i].kind         = stt_pkg::KIND_BYTE;
            res_next[i].char_value   = '0;
            res_next[i].position     = '0;
            res_next[i].token_length = '0;
            res_next[i].final_res    = 1'b0;
        end

        unique case (ph)
            stt_pkg::PH_SKIP: begin
                if (b == stt_pkg::CH_NUL) begin
                    res_next[n].kind = stt_pkg::KIND_EOD;
                    n  = n + 2'd1;
                    ph = stt_pkg::PH_SKIP;
                end else if (b > stt_pkg::CH_SPACE) begin
                    eol = in_eol_reg;
                    sc  = '0;
                    kl  = '0;
                    lkq = 1'b0;
                    lq  = 1'b0;
                    if (b == stt_pkg::CH_SLASH) begin
                        ph = stt_pkg::PH_SLASH;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
            end
            stt_pkg::PH_SLASH: begin
                if (b == stt_pkg::CH_SLASH) begin
                    ph = stt_pkg::PH_LINE;
                end else if (b == stt_pkg::CH_STAR) begin
                    ph = stt_pkg::PH_BLOCK;
                end else begin
                    // held slash opens the token, then this byte is scanned
                    do_begin = 1'b1;
                    bb       = stt_pkg::CH_SLASH;
                    do_body  = 1'b1;
                end
            end
            stt_pkg::PH_LINE: begin
                if (b == stt_pkg::CH_NUL) begin
                    res_next[n].kind = stt_pkg::KIND_EOD;
                    n  = n + 2'd1;
                    ph = stt_pkg::PH_SKIP;
                end else if (b == stt_pkg::CH_LF) begin
                    ph = stt_pkg::PH_SKIP;
                end
            end
            stt_pkg::PH_BLOCK: begin
                if (b == stt_pkg::CH_NUL) begin
                    res_next[n].kind = stt_pkg::KIND_EOD;
                    n  = n + 2'd1;
                    ph = stt_pkg::PH_SKIP;
                end else if (b == stt_pkg::CH_STAR) begin
                    ph = stt_pkg::PH_STAR;
                end
            end
            stt_pkg::PH_STAR: begin
                if (b == stt_pkg::CH_NUL) begin
                    res_next[n].kind = stt_pkg::KIND_EOD;
                    n  = n + 2'd1;
                    ph = stt_pkg::PH_SKIP;
                end else if (b == stt_pkg::CH_SLASH) begin
                    ph = stt_pkg::PH_SKIP;
                end else if (b != stt_pkg::CH_STAR) begin
                    ph = stt_pkg::PH_BLOCK;
                end
            end
            stt_pkg::PH_STRING,
            stt_pkg::PH_PLAIN,
            stt_pkg::PH_EOL: begin
                do_body = 1'b1;
            end
            default: begin
                ph = stt_pkg::PH_SKIP;
            end
        endcase

        // First byte of a token body
        if (do_begin) begin
            if (bb == stt_pkg::CH_QUOTE && !eol) begin
                ph = stt_pkg::PH_STRING;
            end else if (eol) begin
                ph = stt_pkg::PH_EOL;
                lq = (bb == stt_pkg::CH_QUOTE);
                if (sc < CAP_C) begin
                    if (bb >= stt_pkg::CH_SPACE) begin
                        kl  = sc + CNT_W'(1);
                        lkq = (bb == stt_pkg::CH_QUOTE);
                    end
                    // leading quote is dropped
                    if (!(sc == '0 && lq)) begin
                        res_next[n].kind       = stt_pkg::KIND_BYTE;
                        res_next[n].char_value = bb;
                        res_next[n].position   = stt_pkg::POS_W'(sc - CNT_W'(lq));
                        n = n + 2'd1;
                    end
                    sc = sc + CNT_W'(1);
                end
            end else begin
                ph = stt_pkg::PH_PLAIN;
                if (sc < CAP_C) begin
                    res_next[n].kind       = stt_pkg::KIND_BYTE;
                    res_next[n].char_value = bb;
                    res_next[n].position   = stt_pkg::POS_W'(sc);
                    n  = n + 2'd1;
                    sc = sc + CNT_W'(1);
                end
            end
        end

        // Token length should the token end on this byte
        if (ph == stt_pkg::PH_EOL) begin
            len = kl;
            if (lq && len != '0) begin
                len = len - CNT_W'(1);
                if (len != '0 && lkq) begin
                    len = len - CNT_W'(1);
                end
            end
        end else begin
            len = sc;
        end
        if (len >= CAP_C) begin
            len = '0;   // token that reaches capacity reports zero
        end

        // Byte inside a token body
        if (do_body) begin
            if (ph == stt_pkg::PH_PLAIN) begin
                if (b > stt_pkg::CH_SPACE) begin
                    if (sc < CAP_C) begin
                        res_next[n].kind       = stt_pkg::KIND_BYTE;
                        res_next[n].char_value = b;
                        res_next[n].position   = stt_pkg::POS_W'(sc);
                        n  = n + 2'd1;
                        sc = sc + CNT_W'(1);
                    end
                end else begin
                    res_next[n].kind         = stt_pkg::KIND_END;
                    res_next[n].token_length = stt_pkg::LEN_W'(len);
                    n  = n + 2'd1;
                    ph = stt_pkg::PH_SKIP;
                    if (b == stt_pkg::CH_NUL) begin
                        res_next[n].kind = stt_pkg::KIND_EOD;
                        n = n + 2'd1;
                    end
                end
            end else if (ph == stt_pkg::PH_EOL) begin
                if (b == stt_pkg::CH_LF || b == stt_pkg::CH_CR ||
                    b == stt_pkg::CH_NUL) begin
                    res_next[n].kind         = stt_pkg::KIND_END;
                    res_next[n].token_length = stt_pkg::LEN_W'(len);
                    n  = n + 2'd1;
                    ph = stt_pkg::PH_SKIP;
                    if (b == stt_pkg::CH_NUL) begin
                        res_next[n].kind = stt_pkg::KIND_EOD;
                        n = n + 2'd1;
                    end
                end else if (sc < CAP_C) begin
                    if (b >= stt_pkg::CH_SPACE) begin
                        kl  = sc + CNT_W'(1);
                        lkq = (b == stt_pkg::CH_QUOTE);
                    end
                    if (!(sc == '0 && lq)) begin
                        res_next[n].kind       = stt_pkg::KIND_BYTE;
                        res_next[n].char_value = b;
                        res_next[n].position   = stt_pkg::POS_W'(sc - CNT_W'(lq));
                        n = n + 2'd1;
                    end
                    sc = sc + CNT_W'(1);
                end
            end else begin
                // quoted string
                if (b == stt_pkg::CH_QUOTE || b == stt_pkg::CH_NUL) begin
                    res_next[n].kind         = stt_pkg::KIND_END;
                    res_next[n].token_length = stt_pkg::LEN_W'(len);
                    n  = n + 2'd1;
                    ph = stt_pkg::PH_SKIP;
                    if (b == stt_pkg::CH_NUL) begin
                        res_next[n].kind = stt_pkg::KIND_EOD;
                        n = n + 2'd1;
                    end
                end else if (sc < CAP_C) begin
                    res_next[n].kind       = stt_pkg::KIND_BYTE;
                    res_next[n].char_value = b;
                    res_next[n].position   = stt_pkg::POS_W'(sc);
                    n  = n + 2'd1;
                    sc = sc + CNT_W'(1);
                end
            end
        end

        for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
            res_next[i].final_res = (n != 2'd0) && (2'(i) == n - 2'd1);
        end

        phase_next      = ph;
        eol_mode_next   = eol;
        stored_cnt_next = sc;
        kept_len_next   = kl;
        last_quote_next = lkq;
        lead_quote_next = lq;
        res_cnt_next    = n;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_eol_reg  <= s_axis_tuser;
        end
    end

    // Scanner state advances when a byte moves into the result bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= stt_pkg::PH_SKIP;
            eol_mode_reg   <= 1'b0;
            stored_cnt_reg <= '0;
            kept_len_reg   <= '0;
            last_quote_reg <= 1'b0;
            lead_quote_reg <= 1'b0;
        end else if (move) begin
            phase_reg      <= phase_next;
            eol_mode_reg   <= eol_mode_next;
            stored_cnt_reg <= stored_cnt_next;
            kept_len_reg   <= kept_len_next;
            last_quote_reg <= last_quote_next;
            lead_quote_reg <= lead_quote_next;
        end
    end

    // Result bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_left_reg <= 2'd0;
            rd_ptr_reg   <= 2'd0;
        end else if (move) begin
            res_left_reg <= res_cnt_next;
            rd_ptr_reg   <= 2'd0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            res_left_reg <= res_left_reg - 2'd1;
            rd_ptr_reg   <= rd_ptr_reg + 2'd1;
        end
        if (move) begin
            for (int i = 0; i < stt_pkg::MAX_RES; i++) begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

### verif/tb_script_text_tokenizer.sv
// Self-checking testbench for script_text_tokenizer: streams text bytes in,
// predicts every token byte, token end and end-of-data result, and scoreboards them.
// Depends on stt_pkg and the script_text_tokenizer RTL.
module tb_script_text_tokenizer;

    localparam int TOKEN_CAP   = 1024;
    localparam int HOLD_CYCLES = 300;  // long receiver hold-off
    localparam int TAIL_CYCLES = 10;   // margin after the queues drain

    // One pending text byte with its end-of-line request flag
    typedef struct packed {
        logic       eol;
        logic [7:0] text;
    } text_item_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] text_byte
    logic        s_axis_tuser  = 1'b0;   // [0] until_eol
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [7:0] char_value, [17:8] position,
                                         // [27:18] token_length, [31:28] zero
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;

    script_text_tokenizer #(
        .TOKEN_CAPACITY(TOKEN_CAP)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    // Stimulus and scoreboard storage
    text_item_t      text_q[$];          // bytes waiting to be sent
    stt_pkg::res_t   scan_results_q[$];  // results predicted, not yet seen
    stt_pkg::res_t   step_res[$];        // results of the byte being scanned
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_req  = 0;      // bumped by the sequencer to ask for a hold-off
    int          hold_ack  = 0;
    int          hold_left = 0;
    logic        in_fire   = 1'b0;   // input transfer at the last rising edge
    int          err_cnt   = 0;

    // Scanner state mirror
    stt_pkg::phase_t scan_ph    = stt_pkg::PH_SKIP;
    bit              eol_on     = 1'b0;
    int unsigned     n_stored   = 0;
    int unsigned     n_kept     = 0;
    bit              kept_quote = 1'b0;
    bit              lead_quote = 1'b0;

    // ------------------------------------------------------------------
    // Token scanner prediction
    // ------------------------------------------------------------------
    function automatic void add_result(stt_pkg::kind_t k, logic [7:0] ch,
                                       int unsigned pos, int unsigned len);
        stt_pkg::res_t r;
        r.kind         = k;
        r.char_value   = ch;
        r.position     = pos[9:0];
        r.token_length = len[9:0];
        r.final_res    = 1'b0;
        step_res.push_back(r);
    endfunction

    // Plain and string bytes: stored up to capacity, extra bytes dropped silently
    function automatic void store_plain(logic [7:0] b);
        if (n_stored < TOKEN_CAP) begin
            add_result(stt_pkg::KIND_BYTE, b, n_stored, 0);
            n_stored++;
        end
    endfunction

    // End-of-line bytes: track the last byte at or above space for trimming;
    // a leading quote is swallowed and shifts later positions down by one
    function automatic void store_eol(logic [7:0] b);
        if (n_stored < TOKEN_CAP) begin
            if (b >= stt_pkg::CH_SPACE) begin
                n_kept     = n_stored + 1;
                kept_quote = (b == stt_pkg::CH_QUOTE);
            end
            if (!(n_stored == 0 && lead_quote))
                add_result(stt_pkg::KIND_BYTE, b, n_stored - 32'(lead_quote), 0);
            n_stored++;
        end
    endfunction

    function automatic void close_token();
        int unsigned len;
        if (scan_ph == stt_pkg::PH_EOL) begin
            len = n_kept;
            if (lead_quote && len > 0) begin
                len--;
                if (len > 0 && kept_quote)
                    len--;
            end
        end else begin
            len = n_stored;
        end
        if (len >= TOKEN_CAP)
            len = 0;  // full token reads back as empty
        add_result(stt_pkg::KIND_END, 8'h00, 0, len);
    endfunction

    function automatic void close_data();
        add_result(stt_pkg::KIND_EOD, 8'h00, 0, 0);
        scan_ph = stt_pkg::PH_SKIP;
    endfunction

    function automatic void start_body(logic [7:0] b);
        if (b == stt_pkg::CH_QUOTE && !eol_on) begin
            scan_ph = stt_pkg::PH_STRING;
        end else if (eol_on) begin
            scan_ph    = stt_pkg::PH_EOL;
            lead_quote = (b == stt_pkg::CH_QUOTE);
            store_eol(b);
        end else begin
            scan_ph = stt_pkg::PH_PLAIN;
            store_plain(b);
        end
    endfunction

    function automatic void body_byte(logic [7:0] b);
        if (scan_ph == stt_pkg::PH_PLAIN) begin
            if (b > stt_pkg::CH_SPACE) begin
                store_plain(b);
            end else begin
                close_token();
                scan_ph = stt_pkg::PH_SKIP;
                if (b == stt_pkg::CH_NUL)
                    close_data();
            end
        end else if (scan_ph == stt_pkg::PH_EOL) begin
            if (b == stt_pkg::CH_LF || b == stt_pkg::CH_CR) begin
                close_token();
                scan_ph = stt_pkg::PH_SKIP;
            end else if (b == stt_pkg::CH_NUL) begin
                close_token();
                close_data();
            end else begin
                store_eol(b);
            end
        end else begin
            if (b == stt_pkg::CH_QUOTE) begin
                close_token();
                scan_ph = stt_pkg::PH_SKIP;
            end else if (b == stt_pkg::CH_NUL) begin
                close_token();
                close_data();
            end else begin
                store_plain(b);
            end
        end
    endfunction

    // Scan one accepted byte and queue the results it causes, tlast on the last
    function automatic void scan_byte(logic [7:0] b, logic ue);
        stt_pkg::res_t r;
        step_res.delete();
        case (scan_ph)
            stt_pkg::PH_SKIP: begin
                if (b == stt_pkg::CH_NUL) begin
                    close_data();
                end else if (b > stt_pkg::CH_SPACE) begin
                    eol_on     = ue;
                    n_stored   = 0;
                    n_kept     = 0;
                    kept_quote = 1'b0;
                    lead_quote = 1'b0;
                    if (b == stt_pkg::CH_SLASH)
                        scan_ph = stt_pkg::PH_SLASH;
                    else
                        start_body(b);
                end
            end
            stt_pkg::PH_SLASH: begin
                // held slash turns into a token's first byte if no comment follows
                if (b == stt_pkg::CH_SLASH) begin
                    scan_ph = stt_pkg::PH_LINE;
                end else if (b == stt_pkg::CH_STAR) begin
                    scan_ph = stt_pkg::PH_BLOCK;
                end else begin
                    start_body(stt_pkg::CH_SLASH);
                    body_byte(b);
                end
            end
            stt_pkg::PH_LINE: begin
                if (b == stt_pkg::CH_NUL)
                    close_data();
                else if (b == stt_pkg::CH_LF)
                    scan_ph = stt_pkg::PH_SKIP;
            end
            stt_pkg::PH_BLOCK: begin
                if (b == stt_pkg::CH_NUL)
                    close_data();
                else if (b == stt_pkg::CH_STAR)
                    scan_ph = stt_pkg::PH_STAR;
            end
            stt_pkg::PH_STAR: begin
                if (b == stt_pkg::CH_NUL)
                    close_data();
                else if (b == stt_pkg::CH_SLASH)
                    scan_ph = stt_pkg::PH_SKIP;
                else if (b != stt_pkg::CH_STAR)
                    scan_ph = stt_pkg::PH_BLOCK;
            end
            default: body_byte(b);
        endcase
        foreach (step_res[i]) begin
            r           = step_res[i];
            r.final_res = (i == step_res.size() - 1);
            scan_results_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic void push_text(logic [7:0] b, logic ue);
        text_item_t it;
        it.text = b;
        it.eol  = ue;
        text_q.push_back(it);
    endfunction

    function automatic logic [7:0] any_but(int unsigned lo, int unsigned hi,
                                           logic [7:0] x1, logic [7:0] x2,
                                           logic [7:0] x3);
        logic [7:0] b;
        do
            b = rand_byte(lo, hi);
        while (b == x1 || b == x2 || b == x3);
        return b;
    endfunction

    // One random chunk of script text; returns a rough count of the token and
    // end-of-data bytes it queued (whitespace runs and comments count zero)
    function automatic int gen_chunk();
        int unsigned sel;
        int unsigned n;
        int          cnt;
        sel = $urandom_range(99);
        cnt = 0;
        if (sel < 8) begin
            // whitespace run
            n = $urandom_range(3, 1);
            repeat (n) push_text(rand_byte(1, 32'(stt_pkg::CH_SPACE)), rand_bit());
        end else if (sel < 36) begin
            // plain token
            n = $urandom_range(6, 1);
            push_text(any_but(33, 255, stt_pkg::CH_QUOTE, stt_pkg::CH_SLASH,
                              stt_pkg::CH_QUOTE), 1'b0);
            repeat (n - 1) push_text(rand_byte(33, 255), rand_bit());
            push_text(($urandom_range(9) == 0) ? stt_pkg::CH_NUL :
                      rand_byte(1, 32'(stt_pkg::CH_SPACE)), rand_bit());
            cnt = n + 1;
        end else if (sel < 50) begin
            // quoted string, any nonzero byte inside but the quote
            n = $urandom_range(5, 0);
            push_text(stt_pkg::CH_QUOTE, 1'b0);
            repeat (n) push_text(any_but(1, 255, stt_pkg::CH_QUOTE, stt_pkg::CH_QUOTE,
                                         stt_pkg::CH_QUOTE), rand_bit());
            push_text(($urandom_range(7) == 0) ? stt_pkg::CH_NUL : stt_pkg::CH_QUOTE,
                      rand_bit());
            cnt = n + 2;
        end else if (sel < 66) begin
            // rest-of-line token, maybe quoted, maybe with trailing control bytes
            n = $urandom_range(6, 0);
            push_text(($urandom_range(3) == 0) ? stt_pkg::CH_QUOTE :
                      any_but(33, 255, stt_pkg::CH_QUOTE, stt_pkg::CH_SLASH,
                              stt_pkg::CH_QUOTE), 1'b1);
            repeat (n) push_text(any_but(1, 255, stt_pkg::CH_LF, stt_pkg::CH_CR,
                                         stt_pkg::CH_LF), rand_bit());
            if ($urandom_range(1))
                push_text(stt_pkg::CH_QUOTE, rand_bit());
            repeat ($urandom_range(2)) push_text(any_but(1, 31, stt_pkg::CH_LF,
                                                         stt_pkg::CH_CR, stt_pkg::CH_LF),
                                                 rand_bit());
            sel = $urandom_range(5);
            push_text((sel == 0) ? stt_pkg::CH_NUL :
                      (sel < 3) ? stt_pkg::CH_CR : stt_pkg::CH_LF, rand_bit());
            cnt = n + 3;
        end else if (sel < 76) begin
            // line comment
            n = $urandom_range(4, 0);
            push_text(stt_pkg::CH_SLASH, rand_bit());
            push_text(stt_pkg::CH_SLASH, rand_bit());
            repeat (n) push_text(any_but(1, 255, stt_pkg::CH_LF, stt_pkg::CH_LF,
                                         stt_pkg::CH_LF), rand_bit());
            push_text(($urandom_range(5) == 0) ? stt_pkg::CH_NUL : stt_pkg::CH_LF,
                      rand_bit());
        end else if (sel < 86) begin
            // block comment
            n = $urandom_range(4, 0);
            push_text(stt_pkg::CH_SLASH, rand_bit());
            push_text(stt_pkg::CH_STAR, rand_bit());
            repeat (n) push_text(any_but(1, 255, stt_pkg::CH_STAR, stt_pkg::CH_STAR,
                                         stt_pkg::CH_STAR), rand_bit());
            repeat ($urandom_range(2, 1)) push_text(stt_pkg::CH_STAR, rand_bit());
            push_text(($urandom_range(5) == 0) ? stt_pkg::CH_NUL : stt_pkg::CH_SLASH,
                      rand_bit());
        end else if (sel < 91) begin
            push_text(stt_pkg::CH_NUL, rand_bit());
            cnt = 1;
        end else begin
            // noise
            n = $urandom_range(3, 1);
            repeat (n) push_text(rand_byte(0, 255), rand_bit());
            cnt = n;
        end
        return cnt;
    endfunction

    // Sender pause: wait until every queued byte went in and every result came out
    task automatic drain();
        while (text_q.size() != 0 || scan_results_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(int n, int unsigned spct, int unsigned rpct);
        int got;
        send_idle_pct  = spct;
        recv_stall_pct = rpct;
        got = 0;
        while (got < n)
            got += gen_chunk();
        drain();
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the head of text_q at the falling edge; valid is held
    // until the transfer happens, then an idle gap may follow
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!s_axis_tvalid || in_fire)) begin
            if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= text_q[0].text;
                s_axis_tuser  <= text_q[0].eol;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off counted here on request
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [31:0] want_v,
                                        logic [31:0] got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     want_v, got_v);
            err_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, predict from each input transfer and
    // compare each output transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        text_item_t    it;
        stt_pkg::res_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                it = text_q.pop_front();
                scan_byte(it.text, it.eol);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (scan_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %0h %0h %0b",
                             $time, "actual kind/data/last", m_axis_tuser,
                             m_axis_tdata, m_axis_tlast);
                    err_cnt++;
                end else begin
                    want = scan_results_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                    check_field("char_value", 32'(want.char_value),
                                32'(m_axis_tdata[7:0]));
                    check_field("position", 32'(want.position),
                                32'(m_axis_tdata[17:8]));
                    check_field("token_length", 32'(want.token_length),
                                32'(m_axis_tdata[27:18]));
                    check_field("tdata pad", 32'd0, 32'(m_axis_tdata[31:28]));
                    check_field("tlast", 32'(want.final_res), 32'(m_axis_tlast));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed text, no idling
        // plain token at both byte extremes, ended by NUL (token end + end of data)
        push_text(8'h21, 1'b0); push_text(8'hFF, 1'b1); push_text(stt_pkg::CH_NUL, 1'b0);
        // string holding a control byte
        push_text(stt_pkg::CH_QUOTE, 1'b0); push_text(8'h01, 1'b0);
        push_text(stt_pkg::CH_QUOTE, 1'b0);
        // NUL inside a string
        push_text(stt_pkg::CH_QUOTE, 1'b0); push_text(8'h78, 1'b0);
        push_text(stt_pkg::CH_NUL, 1'b0);
        // line comment
        push_text(stt_pkg::CH_SLASH, 1'b0); push_text(stt_pkg::CH_SLASH, 1'b1);
        push_text(stt_pkg::CH_LF, 1'b0);
        // block comment with a double star and a star before another byte
        push_text(stt_pkg::CH_SLASH, 1'b0); push_text(stt_pkg::CH_STAR, 1'b0);
        push_text(stt_pkg::CH_STAR, 1'b0); push_text(8'h71, 1'b0);
        push_text(stt_pkg::CH_STAR, 1'b0); push_text(stt_pkg::CH_SLASH, 1'b0);
        // held slash becomes a plain token
        push_text(stt_pkg::CH_SLASH, 1'b0); push_text(8'h6B, 1'b0);
        push_text(stt_pkg::CH_SPACE, 1'b0);
        // quoted rest-of-line token with a trailing tab: quotes stripped, tab trimmed
        push_text(stt_pkg::CH_QUOTE, 1'b1); push_text(8'h68, 1'b0);
        push_text(stt_pkg::CH_QUOTE, 1'b0); push_text(8'h09, 1'b0);
        push_text(stt_pkg::CH_CR, 1'b0);
        // NUL inside a rest-of-line token
        push_text(8'h77, 1'b1); push_text(stt_pkg::CH_NUL, 1'b0);
        drain();

        run_random(26, 0, 0);
        run_random(26, 87, 0);
        run_random(26, 0, 87);
        run_random(26, 30, 30);

        // Backpressure: sender keeps offering while the receiver holds off
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (text_q.size() < 40)
            void'(gen_chunk());
        hold_req++;
        drain();

        if (err_cnt == 0 && scan_results_q.size() == 0) begin
            $display("[script_text_tokenizer] OK");
        end else begin
            $display("[script_text_tokenizer] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("[script_text_tokenizer] ERROR");
        $finish;
    end

endmodule
